>>> sv/temp_sensor_vref_calibration_core_assert.svh
// Assertion macros shared by the calibration core modules.
`ifndef TEMP_SENSOR_VREF_CALIBRATION_CORE_ASSERT_SVH
`define TEMP_SENSOR_VREF_CALIBRATION_CORE_ASSERT_SVH
`ifndef SYNTH
`define VCAL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vcal: implication check failed");
`define VCAL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vcal: next-cycle check failed");
`else
`define VCAL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define VCAL_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/vcal_pkg.sv
package vcal_pkg;

    localparam int SAMPLE_BITS_DEF = 12;

    typedef struct packed {
        logic [11:0] sensor_sample;
        logic [11:0] supply_quarter_sample;
    } t_in;

    typedef struct packed {
        logic [11:0]        corrected_ref_mv;
        logic [15:0]        supply_mv;
        logic signed [15:0] temperature_tenths;
        logic               calibration_error;
    } t_out;

    typedef struct packed {
        logic [11:0] room_temp_tenths;
        logic [11:0] hot_temp_tenths;
        logic [10:0] room_ref_mv;
        logic [10:0] hot_ref_mv;
        logic [11:0] room_adc_code;
        logic [11:0] hot_adc_code;
    } t_cfg;

    // Item as classified by the front end and held in the queue.
    typedef struct packed {
        logic               err;
        logic [11:0]        s;
        logic [11:0]        q;
        logic signed [12:0] sa;
    } t_item;

    localparam logic [2:0] CFG_ROOM_TEMP = 3'd0;
    localparam logic [2:0] CFG_HOT_TEMP  = 3'd1;
    localparam logic [2:0] CFG_ROOM_REF  = 3'd2;
    localparam logic [2:0] CFG_HOT_REF   = 3'd3;
    localparam logic [2:0] CFG_ROOM_ADC  = 3'd4;
    localparam logic [2:0] CFG_HOT_ADC   = 3'd5;

    localparam t_cfg CFG_RESET = '{
        room_temp_tenths: 12'd250,
        hot_temp_tenths:  12'd850,
        room_ref_mv:      11'd1000,
        hot_ref_mv:       11'd1000,
        room_adc_code:    12'd2000,
        hot_adc_code:     12'd2500
    };

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam logic [QPTR_W:0] QUEUE_CNT_FULL = (QPTR_W + 1)'(QUEUE_DEPTH);

    // Reciprocals for exact truncating division of bounded values.
    // x / 1000 == (x * M1000) >> 34 for x < 2**24.
    localparam logic [24:0] M1000     = 25'd17179870;
    localparam int          M1000_SH  = 34;
    // x / 100 == (x * M100) >> 30 for x < 2**22.
    localparam logic [23:0] M100      = 24'd10737419;
    localparam int          M100_SH   = 30;

endpackage

>>> sv/vcal_front.sv
module vcal_front
    import vcal_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_in   i_in_data,
    input  t_cfg  i_cfg,
    input  logic  i_full,
    output logic  o_push,
    output t_item o_item
);

    localparam logic [11:0] SMASK = 12'(((64'd1 << SAMPLE_BITS) - 64'd1));

    logic [11:0] w_s;

    assign w_s = i_in_data.sensor_sample & SMASK;

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;

    // Coinciding calibration points leave a zero divisor.
    assign o_item.err = (i_cfg.hot_adc_code == i_cfg.room_adc_code) ||
                        (i_cfg.hot_temp_tenths == i_cfg.room_temp_tenths);
    assign o_item.s   = w_s;
    assign o_item.q   = i_in_data.supply_quarter_sample & SMASK;
    assign o_item.sa  = $signed({1'b0, w_s}) - $signed({1'b0, i_cfg.room_adc_code});

endmodule

>>> sv/vcal_fifo.sv
`include "temp_sensor_vref_calibration_core_assert.svh"
module vcal_fifo
    import vcal_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_item
);

    t_item             r_mem [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == QUEUE_CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    `VCAL_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, r_count == QUEUE_CNT_FULL, !i_push)
    `VCAL_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, r_count == '0, !i_pop)
    `VCAL_ASSERT_NXT(a_count_pass, i_clk, i_rst_n, i_push && i_pop, $stable(r_count))

endmodule

>>> sv/vcal_div.sv
module vcal_div
    import vcal_pkg::*;
#(
    parameter int NW = 32,
    parameter int DW = 13,
    parameter int PW = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [NW-1:0] i_num,
    input  logic signed [DW-1:0] i_den,
    input  logic [PW-1:0]        i_side,
    output logic                 o_valid,
    output logic signed [NW-1:0] o_quo,
    output logic [PW-1:0]        o_side
);

    // One quotient bit per stage; the numerator register shifts quotient bits in.
    logic          r_vld  [0:NW];
    logic          r_neg  [0:NW];
    logic [DW-1:0] r_rem  [0:NW];
    logic [NW-1:0] r_nq   [0:NW];
    logic [DW-1:0] r_den  [0:NW];
    logic [PW-1:0] r_side [0:NW];

    logic [NW-1:0] w_anum;
    logic [DW-1:0] w_aden;

    assign w_anum = i_num[NW-1] ? (~i_num + 1'b1) : i_num;
    assign w_aden = i_den[DW-1] ? (~i_den + 1'b1) : i_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg[0]  <= i_num[NW-1] ^ i_den[DW-1];
            r_rem[0]  <= '0;
            r_nq[0]   <= w_anum;
            r_den[0]  <= w_aden;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [DW:0] w_tmp;
        logic [DW:0] w_diff;
        logic        w_ge;

        assign w_tmp  = {r_rem[k], r_nq[k][NW-1]};
        assign w_diff = w_tmp - {1'b0, r_den[k]};
        assign w_ge   = (w_tmp >= {1'b0, r_den[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[k+1]  <= r_neg[k];
                r_rem[k+1]  <= w_ge ? w_diff[DW-1:0] : w_tmp[DW-1:0];
                r_nq[k+1]   <= {r_nq[k][NW-2:0], w_ge};
                r_den[k+1]  <= r_den[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_vld[NW];
    assign o_quo   = r_neg[NW] ? (~r_nq[NW] + 1'b1) : r_nq[NW];
    assign o_side  = r_side[NW];

endmodule

>>> sv/vcal_back.sv
`include "temp_sensor_vref_calibration_core_assert.svh"
module vcal_back
    import vcal_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_empty,
    input  t_item i_item,
    output logic  o_pop,
    output logic  o_out_valid,
    output t_out  o_out_data,
    input  logic  i_out_stall
);

    localparam int SUP_SHIFT = SAMPLE_BITS - 2;

    logic w_en;
    logic r_out_valid;

    logic signed [12:0] w_dtemp;
    logic signed [12:0] w_dcode;
    logic signed [11:0] w_dref;
    logic signed [19:0] w_d100;
    logic signed [19:0] w_t100;

    assign w_en  = !r_out_valid || !i_out_stall;
    assign o_pop = w_en && !i_empty;

    assign w_dtemp = $signed({1'b0, i_cfg.hot_temp_tenths}) -
                     $signed({1'b0, i_cfg.room_temp_tenths});
    assign w_dcode = $signed({1'b0, i_cfg.hot_adc_code}) -
                     $signed({1'b0, i_cfg.room_adc_code});
    assign w_dref  = $signed({1'b0, i_cfg.hot_ref_mv}) -
                     $signed({1'b0, i_cfg.room_ref_mv});
    assign w_d100  = w_dtemp * 20'sd100;
    assign w_t100  = $signed({8'b0, i_cfg.room_temp_tenths}) * 20'sd100;

    // Stage 1: interpolation numerator of the coarse temperature.
    logic               r_v1;
    logic signed [31:0] r_n1;
    logic [24:0]        r_side1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n1    <= w_d100 * $signed(i_item.sa);
            r_side1 <= {i_item.err, i_item.s, i_item.q};
        end
    end

    logic               w_v1d;
    logic signed [31:0] w_x1;
    logic [24:0]        w_side1d;

    vcal_div #(.NW(32), .DW(13), .PW(25)) u_div_coarse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v1),
        .i_num   (r_n1),
        .i_den   (w_dcode),
        .i_side  (r_side1),
        .o_valid (w_v1d),
        .o_quo   (w_x1),
        .o_side  (w_side1d)
    );

    // Stage 2: reference slope times the coarse offset. Dividing by
    // dtemp and then by 100 equals one division by 100*dtemp.
    logic               r_v2;
    logic signed [42:0] r_p;
    logic [24:0]        r_side2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= w_v1d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p     <= w_dref * w_x1;
            r_side2 <= w_side1d;
        end
    end

    logic               w_v2d;
    logic signed [42:0] w_q2;
    logic [24:0]        w_side2d;

    vcal_div #(.NW(43), .DW(20), .PW(25)) u_div_ref (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v2),
        .i_num   (r_p),
        .i_den   (w_d100),
        .i_side  (r_side2),
        .o_valid (w_v2d),
        .o_quo   (w_q2),
        .o_side  (w_side2d)
    );

    // Stage 3: corrected reference, saturated.
    logic signed [43:0] w_vraw;
    logic               r_v3;
    logic [11:0]        r_vref3;
    logic [24:0]        r_side3;

    assign w_vraw = w_q2 + $signed({1'b0, i_cfg.room_ref_mv});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v3 <= w_v2d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_vraw < 44'sd0) begin
                r_vref3 <= '0;
            end else if (w_vraw > 44'sd4095) begin
                r_vref3 <= 12'hFFF;
            end else begin
                r_vref3 <= w_vraw[11:0];
            end
            r_side3 <= w_side2d;
        end
    end

    // Stage 4: scale both samples by the reference.
    logic        r_v4;
    logic        r_err4;
    logic [11:0] r_vref4;
    logic [23:0] r_sv;
    logic [23:0] r_qv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_err4  <= r_side3[24];
            r_vref4 <= r_vref3;
            r_sv    <= r_side3[23:12] * r_vref3;
            r_qv    <= r_side3[11:0] * r_vref3;
        end
    end

    // Stage 5: divide by 1000 through the reciprocal; supply shift and clamp.
    logic [23:0] w_qsh;
    logic        r_v5;
    logic        r_err5;
    logic [11:0] r_vref5;
    logic [48:0] r_mm;
    logic [15:0] r_sup5;

    assign w_qsh = r_qv >> SUP_SHIFT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (w_en) begin
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_err5  <= r_err4;
            r_vref5 <= r_vref4;
            r_mm    <= r_sv * M1000;
            r_sup5  <= (|w_qsh[23:16]) ? 16'hFFFF : w_qsh[15:0];
        end
    end

    // Stage 6: fine interpolation numerator.
    logic [14:0]        w_m;
    logic signed [16:0] w_ma;
    logic               r_v6;
    logic signed [33:0] r_n3;
    logic [28:0]        r_side6;

    assign w_m  = r_mm[M1000_SH+14:M1000_SH];
    assign w_ma = $signed({2'b0, w_m}) - $signed({5'b0, i_cfg.room_adc_code});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else if (w_en) begin
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n3    <= w_d100 * w_ma;
            r_side6 <= {r_err5, r_vref5, r_sup5};
        end
    end

    logic               w_v3d;
    logic signed [33:0] w_q3;
    logic [28:0]        w_side3d;

    vcal_div #(.NW(34), .DW(13), .PW(29)) u_div_fine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v6),
        .i_num   (r_n3),
        .i_den   (w_dcode),
        .i_side  (r_side6),
        .o_valid (w_v3d),
        .o_quo   (w_q3),
        .o_side  (w_side3d)
    );

    // Stage 7: fine temperature in hundredths of a tenth. Anything past the 16-bit
    // result range is flagged here and saturated at the output, so the rest stays narrow.
    logic signed [34:0] w_fine;
    logic [34:0]        w_afine;
    logic               r_v7;
    logic               r_hi7;
    logic               r_lo7;
    logic               r_neg7;
    logic [21:0]        r_abs7;
    logic [28:0]        r_side7;

    assign w_fine  = w_q3 + w_t100;
    assign w_afine = w_fine[34] ? (~w_fine + 1'b1) : w_fine;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7 <= 1'b0;
        end else if (w_en) begin
            r_v7 <= w_v3d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hi7   <= (w_fine >= 35'sd3276800);
            r_lo7   <= (w_fine <= -35'sd3276800);
            r_neg7  <= w_fine[34];
            r_abs7  <= w_afine[21:0];
            r_side7 <= w_side3d;
        end
    end

    // Stage 8: divide by 100 through the reciprocal.
    logic        r_v8;
    logic        r_hi8;
    logic        r_lo8;
    logic        r_neg8;
    logic [45:0] r_pr;
    logic [28:0] r_side8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v8 <= 1'b0;
        end else if (w_en) begin
            r_v8 <= r_v7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hi8   <= r_hi7;
            r_lo8   <= r_lo7;
            r_neg8  <= r_neg7;
            r_pr    <= r_abs7 * M100;
            r_side8 <= r_side7;
        end
    end

    // Output register.
    logic [15:0] w_t;
    logic [15:0] w_tv;
    t_out        r_out;

    assign w_t  = r_pr[M100_SH+15:M100_SH];
    assign w_tv = r_neg8 ? (~w_t + 1'b1) : w_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_v8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.calibration_error <= r_side8[28];
            if (r_side8[28]) begin
                r_out.corrected_ref_mv   <= '0;
                r_out.supply_mv          <= '0;
                r_out.temperature_tenths <= '0;
            end else begin
                r_out.corrected_ref_mv <= r_side8[27:16];
                r_out.supply_mv        <= r_side8[15:0];
                if (r_hi8) begin
                    r_out.temperature_tenths <= 16'sh7FFF;
                end else if (r_lo8) begin
                    r_out.temperature_tenths <= -16'sh8000;
                end else begin
                    r_out.temperature_tenths <= w_tv;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    logic w_err_out;
    logic w_out_zero;

    assign w_err_out  = r_out_valid && r_out.calibration_error;
    assign w_out_zero = (r_out.corrected_ref_mv == '0) && (r_out.supply_mv == '0) &&
                        (r_out.temperature_tenths == '0);

    `VCAL_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, w_err_out, w_out_zero)

endmodule

>>> sv/temp_sensor_vref_calibration_core.sv
// Channel | Direction | Handshake                | Payload
// --------+-----------+--------------------------+----------------------------
// in      | input     | i_in_valid / o_in_stall  | i_in_data (t_in)
// out     | output    | o_out_valid / i_out_stall| o_out_data (t_out)
// cfg     | input     | i_cfg_we                 | i_cfg_idx, i_cfg_wdata
//
// One transaction is accepted per cycle unless the queue is full; results follow
// in order through the three bit-per-stage dividers (32, 43 and 34 stages).
// Reset is synchronous and active low; it clears valid flags and loads the
// calibration defaults. A stalled output freezes the back pipeline; the four-entry
// queue keeps accepting input until it fills.
module temp_sensor_vref_calibration_core
    import vcal_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [11:0] i_cfg_wdata
);

    t_cfg  r_cfg;
    logic  w_push;
    logic  w_pop;
    logic  w_full;
    logic  w_empty;
    t_item w_item_in;
    t_item w_item_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROOM_TEMP: r_cfg.room_temp_tenths <= i_cfg_wdata;
                CFG_HOT_TEMP:  r_cfg.hot_temp_tenths  <= i_cfg_wdata;
                CFG_ROOM_REF:  r_cfg.room_ref_mv      <= i_cfg_wdata[10:0];
                CFG_HOT_REF:   r_cfg.hot_ref_mv       <= i_cfg_wdata[10:0];
                CFG_ROOM_ADC:  r_cfg.room_adc_code    <= i_cfg_wdata;
                CFG_HOT_ADC:   r_cfg.hot_adc_code     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    vcal_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_cfg      (r_cfg),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_item     (w_item_in)
    );

    vcal_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_item  (w_item_out)
    );

    vcal_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_empty     (w_empty),
        .i_item      (w_item_out),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

>>> dv/tb_temp_sensor_vref_calibration_core.sv
`timescale 1ns / 1ps

module tb_temp_sensor_vref_calibration_core;
    import vcal_pkg::*;

    localparam int DRAIN_CYCLES = 250;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [2:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_IDX_SPARE_HI = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in         i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out        o_out_data;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [11:0] i_cfg_wdata = '0;

    t_cfg cal_regs = CFG_RESET;
    t_out pending_results[$];
    int   send_idle_pct = 0;
    int   out_stall_pct = 0;
    int   errors = 0;
    int   cycles = 0;

    temp_sensor_vref_calibration_core u_dut (.*);

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
            $display("tb_temp_sensor_vref_calibration_core NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Two-point interpolation of temperature, then of the reference, then the
    // fine temperature from the reference-scaled sample.
    function automatic t_out calibrate(t_in d, t_cfg c);
        t_out   r;
        longint s, q, t0, t1, r0, r1, a0, a1, dcode, dtemp, coarse, vref, sup, m, fine;
        s = longint'(d.sensor_sample);
        q = longint'(d.supply_quarter_sample);
        t0 = longint'(c.room_temp_tenths);
        t1 = longint'(c.hot_temp_tenths);
        r0 = longint'(c.room_ref_mv);
        r1 = longint'(c.hot_ref_mv);
        a0 = longint'(c.room_adc_code);
        a1 = longint'(c.hot_adc_code);
        dcode = a1 - a0;
        dtemp = t1 - t0;
        r = '0;
        if (dcode == 0 || dtemp == 0) begin
            r.calibration_error = 1'b1;
            return r;
        end
        coarse = 100 * t0 + (100 * dtemp * (s - a0)) / dcode;
        vref = clamp(r0 + ((r1 - r0) * (coarse - 100 * t0)) / dtemp / 100, 0, 4095);
        sup = clamp((q * vref) >>> (SAMPLE_BITS_DEF - 2), 0, 65535);
        m = (s * vref) / 1000;
        fine = 100 * t0 + (100 * dtemp * (m - a0)) / dcode;
        r.corrected_ref_mv = vref[11:0];
        r.supply_mv = sup[15:0];
        r.temperature_tenths = 16'(clamp(fine / 100, -32768, 32767));
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, o_out_data);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_out_data.corrected_ref_mv !== exp_r.corrected_ref_mv) begin
                    $display("%0t: corrected_ref_mv exp %0d got %0d", $time,
                             exp_r.corrected_ref_mv, o_out_data.corrected_ref_mv);
                    errors++;
                end
                if (o_out_data.supply_mv !== exp_r.supply_mv) begin
                    $display("%0t: supply_mv exp %0d got %0d", $time,
                             exp_r.supply_mv, o_out_data.supply_mv);
                    errors++;
                end
                if (o_out_data.temperature_tenths !== exp_r.temperature_tenths) begin
                    $display("%0t: temperature_tenths exp %0d got %0d", $time,
                             exp_r.temperature_tenths, o_out_data.temperature_tenths);
                    errors++;
                end
                if (o_out_data.calibration_error !== exp_r.calibration_error) begin
                    $display("%0t: calibration_error exp %0b got %0b", $time,
                             exp_r.calibration_error, o_out_data.calibration_error);
                    errors++;
                end
            end
        end
    end

    // One transaction on the input channel; valid stays high when no gap follows.
    task automatic send_sample(logic [11:0] s, logic [11:0] q);
        t_in d;
        d.sensor_sample = s;
        d.supply_quarter_sample = q;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= d;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(calibrate(d, cal_regs));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [11:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_ROOM_TEMP: cal_regs.room_temp_tenths = val;
            CFG_HOT_TEMP:  cal_regs.hot_temp_tenths = val;
            CFG_ROOM_REF:  cal_regs.room_ref_mv = val[10:0];
            CFG_HOT_REF:   cal_regs.hot_ref_mv = val[10:0];
            CFG_ROOM_ADC:  cal_regs.room_adc_code = val;
            CFG_HOT_ADC:   cal_regs.hot_adc_code = val;
            default: ;
        endcase
    endtask

    task automatic load_cal(logic [11:0] t0, logic [11:0] t1, logic [11:0] r0,
                            logic [11:0] r1, logic [11:0] a0, logic [11:0] a1);
        write_reg(CFG_ROOM_TEMP, t0);
        write_reg(CFG_HOT_TEMP, t1);
        write_reg(CFG_ROOM_REF, r0);
        write_reg(CFG_HOT_REF, r1);
        write_reg(CFG_ROOM_ADC, a0);
        write_reg(CFG_HOT_ADC, a1);
        i_cfg_we <= 1'b0;
    endtask

    task automatic directed_samples();
        send_sample(12'd0, 12'd0);
        send_sample(12'hFFF, 12'hFFF);
        send_sample(12'hAAA, 12'h555);
        send_sample(12'h555, 12'hAAA);
        send_sample(cal_regs.room_adc_code, 12'd2048);
        send_sample(cal_regs.hot_adc_code, 12'd1);
    endtask

    task automatic test_defaults();
        directed_samples();
        drain();
    endtask

    task automatic test_extreme_cals();
        // Widest span, reversed slopes, then a one-code span so the reference saturates both ways.
        load_cal(12'd0, 12'd2565, 12'd872, 12'd1128, 12'd0, 12'd4095);
        directed_samples();
        drain();
        load_cal(12'd2565, 12'd0, 12'd1128, 12'd872, 12'd4095, 12'd0);
        directed_samples();
        drain();
        load_cal(12'd0, 12'hFFF, 12'd0, 12'h7FF, 12'd2000, 12'd2001);
        directed_samples();
        drain();
    endtask

    task automatic test_coinciding_points();
        load_cal(12'd250, 12'd850, 12'd1000, 12'd1000, 12'd3000, 12'd3000);
        send_sample(12'd100, 12'd4000);
        send_sample(12'd3000, 12'hFFF);
        drain();
        load_cal(12'd600, 12'd600, 12'd900, 12'd1100, 12'd1000, 12'd3000);
        send_sample(12'd2000, 12'd2000);
        send_sample(12'hFFF, 12'hFFF);
        drain();
    endtask

    task automatic test_spare_index();
        load_cal(12'd250, 12'd850, 12'd950, 12'd1050, 12'd2000, 12'd2500);
        write_reg(CFG_IDX_SPARE_LO, 12'hFFF);
        write_reg(CFG_IDX_SPARE_HI, 12'h000);
        i_cfg_we <= 1'b0;
        send_sample(12'd2200, 12'd3000);
        drain();
    endtask

    task automatic random_phase(int idle_pct, int stall_pct, int count);
        logic [11:0] s;
        send_idle_pct = idle_pct;
        out_stall_pct = stall_pct;
        // Mostly sane calibrations, sometimes any value the register holds.
        if ($urandom_range(3) == 0)
            load_cal(12'($urandom), 12'($urandom), 12'($urandom),
                     12'($urandom), 12'($urandom), 12'($urandom));
        else
            load_cal(12'($urandom_range(2565)), 12'($urandom_range(2565)),
                     12'($urandom_range(1128, 872)), 12'($urandom_range(1128, 872)),
                     12'($urandom_range(4095)), 12'($urandom_range(4095)));
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(9))
                0: s = $urandom_range(1) ? 12'd0 : 12'hFFF;
                1: s = 12'(cal_regs.room_adc_code + $urandom_range(20) - 10);
                default: s = 12'($urandom);
            endcase
            send_sample(s, 12'($urandom));
        end
        drain();
    endtask

    task automatic test_random();
        for (int p = 0; p < 2; p++) begin
            random_phase(0, 0, 170);
            random_phase(53, 0, 170);
            random_phase(0, 53, 170);
            random_phase(28, 28, 170);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_extreme_cals();
        test_coinciding_points();
        test_spare_index();
        test_random();
        if (errors == 0)
            $display("tb_temp_sensor_vref_calibration_core OK");
        else
            $display("tb_temp_sensor_vref_calibration_core NOT OK");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/vcal_pkg.sv
sv/vcal_front.sv
sv/vcal_fifo.sv
sv/vcal_div.sv
sv/vcal_back.sv
sv/temp_sensor_vref_calibration_core.sv
dv/tb_temp_sensor_vref_calibration_core.sv
